FILE: rtl/clipped_draw_to_panel_command_stream_macros.svh
// Assertion macros used by the checker file of the draw command block.
`ifndef CLIPPED_DRAW_TO_PANEL_COMMAND_STREAM_MACROS_SVH
`define CLIPPED_DRAW_TO_PANEL_COMMAND_STREAM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/clpd_pkg.sv
// Package: types, codes and reset values of the draw command block.
`default_nettype none

package clpd_pkg;

  localparam int PADDR_W = 5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_PANEL_W  = 3'd0;
  localparam logic [2:0] REG_PANEL_H  = 3'd1;
  localparam logic [2:0] REG_COL_OFS  = 3'd2;
  localparam logic [2:0] REG_ROW_OFS  = 3'd3;
  localparam logic [2:0] REG_COL_OPC  = 3'd4;
  localparam logic [2:0] REG_ROW_OPC  = 3'd5;
  localparam logic [2:0] REG_MEMW_OPC = 3'd6;

  localparam logic [7:0] RST_PANEL_W  = 8'd128;
  localparam logic [7:0] RST_PANEL_H  = 8'd128;
  localparam logic [7:0] RST_COL_OFS  = 8'd0;
  localparam logic [7:0] RST_ROW_OFS  = 8'd0;
  localparam logic [7:0] RST_COL_OPC  = 8'd42;
  localparam logic [7:0] RST_ROW_OPC  = 8'd43;
  localparam logic [7:0] RST_MEMW_OPC = 8'd44;

  // draw op codes
  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_RECT  = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] span_w;
    logic signed [15:0] span_h;
    logic        [15:0] color;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] run_color;
    logic [15:0] run_count;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [7:0] panel_width;
    logic [7:0] panel_height;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
    logic [7:0] column_set_opcode;
    logic [7:0] row_set_opcode;
    logic [7:0] memory_write_opcode;
  } cfg_t;

  // clipped window handed from front to back
  typedef struct packed {
    logic [7:0]  x0;
    logic [7:0]  w;
    logic [7:0]  y0;
    logic [7:0]  h;
    logic [15:0] color;
  } qent_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_CMD,
    ST_COL_D0,
    ST_COL_D1,
    ST_COL_D2,
    ST_COL_D3,
    ST_ROW_CMD,
    ST_ROW_D0,
    ST_ROW_D1,
    ST_ROW_D2,
    ST_ROW_D3,
    ST_MEMW_CMD,
    ST_RUN
  } step_t;

endpackage

`default_nettype wire

FILE: rtl/clipped_draw_to_panel_command_stream.sv
// Top level: clipped draw requests in, panel command stream out.
//
// Input: a draw request is taken at a clock edge with start high and busy low.
// The front end clips it in the same cycle; a request that leaves nothing
// visible is dropped and yields no items. A visible one goes into a
// four-entry window queue; busy is high only while that queue is full.
// Output: twelve items per visible request, one per cycle, each shown for
// exactly one cycle with out_strobe high: column-set command, four column
// bytes, row-set command, four row bytes, memory-write command and the
// pixel run (last set). The receiver has no stall; items are never held.
// A request passes through the queue, the sequencer state register and the
// output item register before its first item appears. The back-end
// sequencer emits one item per cycle; back-to-back windows run without a
// gap. Dropped requests never enter the queue.
// Configuration: seven 8-bit registers at byte addresses 0..24, written
// via the APB-style port only while the block is idle (the user's duty;
// the block does not enforce it). Reset (rst_n low, synchronous) empties
// the queue, idles the sequencer and loads each register's reset value.
`default_nettype none

module clipped_draw_to_panel_command_stream (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire clpd_pkg::req_t               in_req,
  output logic                              out_strobe,
  output clpd_pkg::item_t                   out_item,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [clpd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  clpd_pkg::cfg_t  cfg;
  clpd_pkg::qent_t q_wdata, q_rdata;
  logic            q_push, q_pop, q_full, q_empty;

  assign busy = q_full;

  clpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clpd_front u_front (
    .start   (start),
    .q_full  (q_full),
    .req     (in_req),
    .cfg     (cfg),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  clpd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  clpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/clpd_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module clpd_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [clpd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output clpd_pkg::cfg_t                    cfg
);

  clpd_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        clpd_pkg::REG_PANEL_W:  cfg_nxt.panel_width         = pwdata[7:0];
        clpd_pkg::REG_PANEL_H:  cfg_nxt.panel_height        = pwdata[7:0];
        clpd_pkg::REG_COL_OFS:  cfg_nxt.column_offset       = pwdata[7:0];
        clpd_pkg::REG_ROW_OFS:  cfg_nxt.row_offset          = pwdata[7:0];
        clpd_pkg::REG_COL_OPC:  cfg_nxt.column_set_opcode   = pwdata[7:0];
        clpd_pkg::REG_ROW_OPC:  cfg_nxt.row_set_opcode      = pwdata[7:0];
        clpd_pkg::REG_MEMW_OPC: cfg_nxt.memory_write_opcode = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      clpd_pkg::REG_PANEL_W:  prdata = {24'd0, cfg_r.panel_width};
      clpd_pkg::REG_PANEL_H:  prdata = {24'd0, cfg_r.panel_height};
      clpd_pkg::REG_COL_OFS:  prdata = {24'd0, cfg_r.column_offset};
      clpd_pkg::REG_ROW_OFS:  prdata = {24'd0, cfg_r.row_offset};
      clpd_pkg::REG_COL_OPC:  prdata = {24'd0, cfg_r.column_set_opcode};
      clpd_pkg::REG_ROW_OPC:  prdata = {24'd0, cfg_r.row_set_opcode};
      clpd_pkg::REG_MEMW_OPC: prdata = {24'd0, cfg_r.memory_write_opcode};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.panel_width         <= clpd_pkg::RST_PANEL_W;
      cfg_r.panel_height        <= clpd_pkg::RST_PANEL_H;
      cfg_r.column_offset       <= clpd_pkg::RST_COL_OFS;
      cfg_r.row_offset          <= clpd_pkg::RST_ROW_OFS;
      cfg_r.column_set_opcode   <= clpd_pkg::RST_COL_OPC;
      cfg_r.row_set_opcode      <= clpd_pkg::RST_ROW_OPC;
      cfg_r.memory_write_opcode <= clpd_pkg::RST_MEMW_OPC;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clpd_front.sv
// Front end: classifies a draw request and clips it to the panel.
`default_nettype none

module clpd_front (
  input  wire logic           start,
  input  wire logic           q_full,
  input  wire clpd_pkg::req_t req,
  input  wire clpd_pkg::cfg_t cfg,
  output logic                q_push,
  output clpd_pkg::qent_t     q_wdata
);

  typedef struct packed {
    logic       vis;
    logic [7:0] start;
    logic [7:0] len;
  } axis_t;

  // clip one axis; 18-bit signed so no sum overflows
  function automatic axis_t clip_axis(input logic signed [17:0] s,
                                      input logic signed [17:0] n,
                                      input logic signed [17:0] lim);
    logic signed [17:0] s1;
    logic signed [17:0] n1;
    logic signed [17:0] n2;
    axis_t              r;
    if (s < 18'sd0) begin
      n1 = n + s;
      s1 = 18'sd0;
    end else begin
      n1 = n;
      s1 = s;
    end
    if (s1 + n1 - 18'sd1 >= lim) begin
      n2 = lim - s1;
    end else begin
      n2 = n1;
    end
    r.vis   = n2 > 18'sd0;
    r.start = s1[7:0];
    r.len   = n2[7:0];
    return r;
  endfunction

  logic signed [17:0] sx, sy, sw, sh, lim_w, lim_h;
  logic               x_in, y_in, vis;
  axis_t              cx, cy;

  assign sx    = 18'(req.pos_x);
  assign sy    = 18'(req.pos_y);
  assign sw    = 18'(req.span_w);
  assign sh    = 18'(req.span_h);
  assign lim_w = $signed({10'd0, cfg.panel_width});
  assign lim_h = $signed({10'd0, cfg.panel_height});
  assign x_in  = (sx >= 18'sd0) && (sx < lim_w);
  assign y_in  = (sy >= 18'sd0) && (sy < lim_h);
  assign cx    = clip_axis(sx, sw, lim_w);
  assign cy    = clip_axis(sy, sh, lim_h);

  always_comb begin
    q_wdata.color = req.color;
    q_wdata.x0    = sx[7:0];
    q_wdata.w     = 8'd1;
    q_wdata.y0    = sy[7:0];
    q_wdata.h     = 8'd1;
    vis           = 1'b0;
    case (req.op)
      clpd_pkg::OP_PIXEL: vis = x_in && y_in;
      clpd_pkg::OP_HLINE: begin
        vis       = y_in && cx.vis;
        q_wdata.x0 = cx.start;
        q_wdata.w  = cx.len;
      end
      clpd_pkg::OP_VLINE: begin
        vis       = x_in && cy.vis;
        q_wdata.y0 = cy.start;
        q_wdata.h  = cy.len;
      end
      clpd_pkg::OP_RECT: begin
        vis       = cx.vis && cy.vis;
        q_wdata.x0 = cx.start;
        q_wdata.w  = cx.len;
        q_wdata.y0 = cy.start;
        q_wdata.h  = cy.len;
      end
      clpd_pkg::OP_FILL: begin
        vis       = (cfg.panel_width != 8'd0) && (cfg.panel_height != 8'd0);
        q_wdata.x0 = 8'd0;
        q_wdata.w  = cfg.panel_width;
        q_wdata.y0 = 8'd0;
        q_wdata.h  = cfg.panel_height;
      end
      default: vis = 1'b0;
    endcase
  end

  // invisible requests are taken and dropped here
  assign q_push = start && !q_full && vis;

endmodule

`default_nettype wire

FILE: rtl/clpd_queue.sv
// Small register queue between the clipping front and the command back end.
`default_nettype none

module clpd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire clpd_pkg::qent_t wdata,
  input  wire logic            pop,
  output clpd_pkg::qent_t      rdata,
  output logic                 full,
  output logic                 empty
);

  clpd_pkg::qent_t                mem_r [clpd_pkg::QUEUE_DEPTH];
  logic [clpd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [clpd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [clpd_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign full    = cnt_r == clpd_pkg::QCNT_W'(clpd_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + clpd_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + clpd_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + clpd_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - clpd_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/clpd_back.sv
// Back end: walks one clipped window through the twelve-item command stream.
`default_nettype none

module clpd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire clpd_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire clpd_pkg::qent_t q_rdata,
  output logic                 q_pop,
  output logic                 out_strobe,
  output clpd_pkg::item_t      out_item
);

  clpd_pkg::step_t state_r, state_nxt;
  clpd_pkg::qent_t cur_r, cur_nxt;
  clpd_pkg::item_t item_r, item_nxt;
  logic            strobe_r, strobe_nxt;
  logic [7:0]      x1, y1;
  logic [15:0]     count;

  assign x1    = cur_r.x0 + cur_r.w - 8'd1;
  assign y1    = cur_r.y0 + cur_r.h - 8'd1;
  assign count = {8'd0, cur_r.w} * {8'd0, cur_r.h};

  // next state
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      clpd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = clpd_pkg::ST_COL_CMD;
        end
      end
      clpd_pkg::ST_COL_CMD:  state_nxt = clpd_pkg::ST_COL_D0;
      clpd_pkg::ST_COL_D0:   state_nxt = clpd_pkg::ST_COL_D1;
      clpd_pkg::ST_COL_D1:   state_nxt = clpd_pkg::ST_COL_D2;
      clpd_pkg::ST_COL_D2:   state_nxt = clpd_pkg::ST_COL_D3;
      clpd_pkg::ST_COL_D3:   state_nxt = clpd_pkg::ST_ROW_CMD;
      clpd_pkg::ST_ROW_CMD:  state_nxt = clpd_pkg::ST_ROW_D0;
      clpd_pkg::ST_ROW_D0:   state_nxt = clpd_pkg::ST_ROW_D1;
      clpd_pkg::ST_ROW_D1:   state_nxt = clpd_pkg::ST_ROW_D2;
      clpd_pkg::ST_ROW_D2:   state_nxt = clpd_pkg::ST_ROW_D3;
      clpd_pkg::ST_ROW_D3:   state_nxt = clpd_pkg::ST_MEMW_CMD;
      clpd_pkg::ST_MEMW_CMD: state_nxt = clpd_pkg::ST_RUN;
      clpd_pkg::ST_RUN: begin
        // chain straight into the next window when one is waiting
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = clpd_pkg::ST_COL_CMD;
        end else begin
          state_nxt = clpd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clpd_pkg::ST_IDLE;
    endcase
  end

  // item for the current step
  always_comb begin
    strobe_nxt          = 1'b1;
    item_nxt.kind       = clpd_pkg::KIND_DATA;
    item_nxt.byte_value = 8'd0;
    item_nxt.run_color  = 16'd0;
    item_nxt.run_count  = 16'd0;
    item_nxt.last       = 1'b0;
    case (state_r)
      clpd_pkg::ST_IDLE: strobe_nxt = 1'b0;
      clpd_pkg::ST_COL_CMD: begin
        item_nxt.kind       = clpd_pkg::KIND_CMD;
        item_nxt.byte_value = cfg.column_set_opcode;
      end
      clpd_pkg::ST_COL_D0: ;
      clpd_pkg::ST_COL_D1: item_nxt.byte_value = cur_r.x0 + cfg.column_offset;
      clpd_pkg::ST_COL_D2: ;
      clpd_pkg::ST_COL_D3: item_nxt.byte_value = x1 + cfg.column_offset;
      clpd_pkg::ST_ROW_CMD: begin
        item_nxt.kind       = clpd_pkg::KIND_CMD;
        item_nxt.byte_value = cfg.row_set_opcode;
      end
      clpd_pkg::ST_ROW_D0: ;
      clpd_pkg::ST_ROW_D1: item_nxt.byte_value = cur_r.y0 + cfg.row_offset;
      clpd_pkg::ST_ROW_D2: ;
      clpd_pkg::ST_ROW_D3: item_nxt.byte_value = y1 + cfg.row_offset;
      clpd_pkg::ST_MEMW_CMD: begin
        item_nxt.kind       = clpd_pkg::KIND_CMD;
        item_nxt.byte_value = cfg.memory_write_opcode;
      end
      clpd_pkg::ST_RUN: begin
        item_nxt.kind      = clpd_pkg::KIND_RUN;
        item_nxt.run_color = cur_r.color;
        item_nxt.run_count = count;
        item_nxt.last      = 1'b1;
      end
      default: strobe_nxt = 1'b0;
    endcase
  end

  assign cur_nxt    = q_pop ? q_rdata : cur_r;
  assign out_strobe = strobe_r;
  assign out_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= clpd_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/clpd_checker.sv
// Port-level checks on the result stream, bound to the top level.
`default_nettype none
`include "clipped_draw_to_panel_command_stream_macros.svh"

module clpd_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_strobe,
  input wire clpd_pkg::item_t out_item
);

  // only the pixel run closes a sequence
  `CLPD_ASSERT_NOW(a_last_on_run, out_strobe,
    out_item.last == (out_item.kind == clpd_pkg::KIND_RUN),
    "last flag does not match pixel run")

  // the run always follows the memory-write command directly
  `CLPD_ASSERT_NOW(a_run_after_cmd, out_strobe && out_item.last,
    $past(out_strobe) && $past(out_item.kind) == clpd_pkg::KIND_CMD,
    "pixel run not preceded by a command")

  // a clipped window is never empty
  `CLPD_ASSERT_NOW(a_run_nonzero, out_strobe && out_item.last,
    out_item.run_count != 16'd0,
    "pixel run with zero count")

  // after a run, the next item can only open a new window
  `CLPD_ASSERT_NEXT(a_after_run, out_strobe && out_item.last,
    !out_strobe || out_item.kind == clpd_pkg::KIND_CMD,
    "item after pixel run is not a command")

endmodule

bind clipped_draw_to_panel_command_stream clpd_checker u_clpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire
